// File: sv/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, constants and register map of the pose fall detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

  // Parameter defaults
  localparam int unsigned TRACKS_DEF      = 64;
  localparam int unsigned VOTE_WINDOW_DEF = 8;
  localparam int unsigned KEYPOINTS_DEF   = 17;
  localparam int unsigned COORD_BITS_DEF  = 12;

  // Fixed field widths
  localparam int unsigned TRACK_W   = 6;
  localparam int unsigned INDEX_W   = 5;
  localparam int unsigned IN_COORD_W = 12;
  localparam int unsigned BOX_W     = 12;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned DROP_W    = 13;
  localparam int unsigned THR_W     = 4;
  localparam int unsigned CENTRE_W  = 14;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned FIFO_DEPTH = 2;

  // Body layout indices
  localparam logic [INDEX_W-1:0] KP_NOSE       = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] KP_L_SHOULDER = INDEX_W'(5);
  localparam logic [INDEX_W-1:0] KP_R_SHOULDER = INDEX_W'(6);
  localparam logic [INDEX_W-1:0] KP_L_HIP      = INDEX_W'(11);
  localparam logic [INDEX_W-1:0] KP_R_HIP      = INDEX_W'(12);
  localparam logic [INDEX_W-1:0] KP_L_KNEE     = INDEX_W'(13);
  localparam logic [INDEX_W-1:0] KP_R_KNEE     = INDEX_W'(14);
  localparam logic [INDEX_W-1:0] KP_L_ANKLE    = INDEX_W'(15);
  localparam logic [INDEX_W-1:0] KP_R_ANKLE    = INDEX_W'(16);

  // Register map (word index)
  localparam logic [REG_IDX_W-1:0] REG_DROP_SPEED   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SIDE_RATIO   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_SIDE_TAN     = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_FRONT_COMP   = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_FRONT_TAN    = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_DYN_TAN      = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_SIT_TAN      = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_VOTE_THRESH  = REG_IDX_W'(7);

  // Register reset values
  localparam logic [DROP_W-1:0] RST_DROP_SPEED  = DROP_W'(40);
  localparam logic [CFG_W-1:0]  RST_SIDE_RATIO  = CFG_W'(384);
  localparam logic [CFG_W-1:0]  RST_SIDE_TAN    = CFG_W'(148);
  localparam logic [CFG_W-1:0]  RST_FRONT_COMP  = CFG_W'(128);
  localparam logic [CFG_W-1:0]  RST_FRONT_TAN   = CFG_W'(256);
  localparam logic [CFG_W-1:0]  RST_DYN_TAN     = CFG_W'(443);
  localparam logic [CFG_W-1:0]  RST_SIT_TAN     = CFG_W'(443);
  localparam logic [THR_W-1:0]  RST_VOTE_THRESH = THR_W'(3);

  typedef struct packed {
    logic [TRACK_W-1:0]    track_id;
    logic [INDEX_W-1:0]    point_index;
    logic [IN_COORD_W-1:0] point_x;
    logic [IN_COORD_W-1:0] point_y;
    logic [BOX_W-1:0]      box_top;
    logic [BOX_W-1:0]      box_width;
    logic [BOX_W-1:0]      box_height;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic [TRACK_W-1:0] result_track;
    logic               fall_confirmed;
  } result_t;

  typedef struct packed {
    logic [DROP_W-1:0] drop_speed_limit;
    logic [CFG_W-1:0]  side_aspect_ratio;
    logic [CFG_W-1:0]  side_angle_tan;
    logic [CFG_W-1:0]  frontal_compression;
    logic [CFG_W-1:0]  frontal_angle_tan;
    logic [CFG_W-1:0]  dynamic_angle_tan;
    logic [CFG_W-1:0]  sitting_angle_tan;
    logic [THR_W-1:0]  vote_threshold;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DECIDE
  } back_state_e;

  // Products formed one per cycle on the shared multiplier
  typedef enum logic [2:0] {
    OP_SIDE_RATIO,
    OP_FRONT_COMP,
    OP_SIDE_TAN,
    OP_FRONT_TAN,
    OP_DYN_TAN,
    OP_SIT_TAN
  } mul_op_e;

  localparam int unsigned MUL_OPS = 6;

endpackage

`default_nettype wire

// File: sv/pfd_regs.sv
// ----------------------------------------------------------------------------
// pfd_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_regs import pfd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [ADDR_W-1:0] paddr_i,
  input  wire logic [DATA_W-1:0] pwdata_i,
  output logic      [DATA_W-1:0] prdata_o,
  output cfg_t                   cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_idx = paddr_i[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drop_speed_limit    <= RST_DROP_SPEED;
      cfg_q.side_aspect_ratio   <= RST_SIDE_RATIO;
      cfg_q.side_angle_tan      <= RST_SIDE_TAN;
      cfg_q.frontal_compression <= RST_FRONT_COMP;
      cfg_q.frontal_angle_tan   <= RST_FRONT_TAN;
      cfg_q.dynamic_angle_tan   <= RST_DYN_TAN;
      cfg_q.sitting_angle_tan   <= RST_SIT_TAN;
      cfg_q.vote_threshold      <= RST_VOTE_THRESH;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DROP_SPEED:  cfg_q.drop_speed_limit    <= pwdata_i[DROP_W-1:0];
        REG_SIDE_RATIO:  cfg_q.side_aspect_ratio   <= pwdata_i[CFG_W-1:0];
        REG_SIDE_TAN:    cfg_q.side_angle_tan      <= pwdata_i[CFG_W-1:0];
        REG_FRONT_COMP:  cfg_q.frontal_compression <= pwdata_i[CFG_W-1:0];
        REG_FRONT_TAN:   cfg_q.frontal_angle_tan   <= pwdata_i[CFG_W-1:0];
        REG_DYN_TAN:     cfg_q.dynamic_angle_tan   <= pwdata_i[CFG_W-1:0];
        REG_SIT_TAN:     cfg_q.sitting_angle_tan   <= pwdata_i[CFG_W-1:0];
        REG_VOTE_THRESH: cfg_q.vote_threshold      <= pwdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DROP_SPEED:  prdata_o = DATA_W'(cfg_q.drop_speed_limit);
      REG_SIDE_RATIO:  prdata_o = DATA_W'(cfg_q.side_aspect_ratio);
      REG_SIDE_TAN:    prdata_o = DATA_W'(cfg_q.side_angle_tan);
      REG_FRONT_COMP:  prdata_o = DATA_W'(cfg_q.frontal_compression);
      REG_FRONT_TAN:   prdata_o = DATA_W'(cfg_q.frontal_angle_tan);
      REG_DYN_TAN:     prdata_o = DATA_W'(cfg_q.dynamic_angle_tan);
      REG_SIT_TAN:     prdata_o = DATA_W'(cfg_q.sitting_angle_tan);
      REG_VOTE_THRESH: prdata_o = DATA_W'(cfg_q.vote_threshold);
      default:         prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/pfd_front.sv
// ----------------------------------------------------------------------------
// pfd_front
// Keypoint front end: gathers doubled joint sums and the head row, and on
// the last word of a frame hands a frame record to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_front import pfd_pkg::*; #(
  parameter int unsigned KEYPOINTS  = KEYPOINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned REC_W      = 1 + TRACK_W + COORD_BITS
                                      + 6 * (COORD_BITS + 1) + 3 * BOX_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  item_t                 item_i,
  output logic                  push_o,
  output logic      [REC_W-1:0] rec_o
);

  localparam int unsigned SUM_W = COORD_BITS + 1;
  localparam int unsigned CNT_W = $clog2(KEYPOINTS + 1);

  logic [CNT_W-1:0]      count_q, count_d, count_upd;
  logic [COORD_BITS-1:0] head_q, head_d, head_upd;
  logic [SUM_W-1:0]      sx_q, sx_d, sx_upd;
  logic [SUM_W-1:0]      sy_q, sy_d, sy_upd;
  logic [SUM_W-1:0]      hx_q, hx_d, hx_upd;
  logic [SUM_W-1:0]      hy_q, hy_d, hy_upd;
  logic [SUM_W-1:0]      ky_q, ky_d, ky_upd;
  logic [SUM_W-1:0]      ay_q, ay_d, ay_upd;
  logic [COORD_BITS-1:0] px, py;
  logic                  full_frame;

  assign px = COORD_BITS'(item_i.point_x);
  assign py = COORD_BITS'(item_i.point_y);

  always_comb begin
    head_upd = head_q;
    sx_upd   = sx_q;
    sy_upd   = sy_q;
    hx_upd   = hx_q;
    hy_upd   = hy_q;
    ky_upd   = ky_q;
    ay_upd   = ay_q;
    case (item_i.point_index)
      KP_NOSE: head_upd = py;
      KP_L_SHOULDER, KP_R_SHOULDER: begin
        sx_upd = sx_q + SUM_W'(px);
        sy_upd = sy_q + SUM_W'(py);
      end
      KP_L_HIP, KP_R_HIP: begin
        hx_upd = hx_q + SUM_W'(px);
        hy_upd = hy_q + SUM_W'(py);
      end
      KP_L_KNEE, KP_R_KNEE:   ky_upd = ky_q + SUM_W'(py);
      KP_L_ANKLE, KP_R_ANKLE: ay_upd = ay_q + SUM_W'(py);
      default: ;
    endcase
    // saturate the point count
    if (count_q < CNT_W'(KEYPOINTS)) begin
      count_upd = count_q + CNT_W'(1);
    end else begin
      count_upd = count_q;
    end
  end

  assign full_frame = (count_upd == CNT_W'(KEYPOINTS));

  // drop the frame state once its last word is taken
  always_comb begin
    if (item_i.last) begin
      count_d = '0;
      head_d  = '0;
      sx_d    = '0;
      sy_d    = '0;
      hx_d    = '0;
      hy_d    = '0;
      ky_d    = '0;
      ay_d    = '0;
    end else begin
      count_d = count_upd;
      head_d  = head_upd;
      sx_d    = sx_upd;
      sy_d    = sy_upd;
      hx_d    = hx_upd;
      hy_d    = hy_upd;
      ky_d    = ky_upd;
      ay_d    = ay_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      hx_q    <= '0;
      hy_q    <= '0;
      ky_q    <= '0;
      ay_q    <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
      head_q  <= head_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
      ky_q    <= ky_d;
      ay_q    <= ay_d;
    end
  end

  assign push_o = accept_i & item_i.last;
  assign rec_o  = {full_frame, item_i.track_id, head_upd,
                   sx_upd, sy_upd, hx_upd, hy_upd, ky_upd, ay_upd,
                   item_i.box_top, item_i.box_width, item_i.box_height};

endmodule

`default_nettype wire

// File: sv/pfd_fifo.sv
// ----------------------------------------------------------------------------
// pfd_fifo
// Short frame-record queue between the front end and the decision engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_fifo import pfd_pkg::*; #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = store_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("frame queue read while empty");

endmodule

`default_nettype wire

// File: sv/pfd_back.sv
// ----------------------------------------------------------------------------
// pfd_back
// Decision engine: per-frame geometry, shared multiplier sequence for the
// angle and ratio tests, per-track centre and vote memory, result word.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_back import pfd_pkg::*; #(
  parameter int unsigned TRACKS      = TRACKS_DEF,
  parameter int unsigned VOTE_WINDOW = VOTE_WINDOW_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned REC_W       = 1 + TRACK_W + COORD_BITS
                                       + 6 * (COORD_BITS + 1) + 3 * BOX_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cfg_t                  cfg_i,
  input  wire logic [REC_W-1:0] rec_i,
  input  wire logic             rec_valid_i,
  output logic                  rec_pop_o,
  output logic                  clearing_o,
  output logic                  result_valid_o,
  output result_t               result_o
);

  localparam int unsigned SUM_W  = COORD_BITS + 1;
  localparam int unsigned SLOT_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned CLR_W  = $clog2(TRACKS + 1);
  localparam int unsigned MB     = (SUM_W > BOX_W) ? SUM_W : BOX_W;
  localparam int unsigned PW     = CFG_W + MB;
  localparam int unsigned CW     = PW + 1;
  localparam int unsigned ENT_W  = 1 + CENTRE_W + VOTE_WINDOW;
  localparam int unsigned VCNT_W = $clog2(VOTE_WINDOW + 1);
  localparam int unsigned CMP_W  = (VCNT_W > THR_W) ? VCNT_W : THR_W;
  localparam int unsigned DIFF_W = CENTRE_W + 2;
  localparam int unsigned STEP_W = 3;
  localparam int unsigned TIDS   = 2 ** TRACK_W;

  // Frame record fields
  logic                  r_ok;
  logic [TRACK_W-1:0]    r_track;
  logic [COORD_BITS-1:0] r_head;
  logic [SUM_W-1:0]      r_sx, r_sy, r_hx, r_hy, r_ky, r_ay;
  logic [BOX_W-1:0]      r_top, r_bw, r_bh;
  logic [TRACK_W-1:0]    in_track;

  logic [REC_W-1:0]      rec_q;
  back_state_e           st_q, st_d;
  logic [STEP_W-1:0]     step_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SLOT_W-1:0]     slot_lut [TIDS];
  logic [CLR_W-1:0]      clr_q;

  logic [ENT_W-1:0]      mem_q [TRACKS];
  logic [ENT_W-1:0]      ent_q;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_wa;
  logic [ENT_W-1:0]      mem_wd;

  logic [SUM_W-1:0]      body2_q, dx2_q, dy2_q;
  logic [CENTRE_W-1:0]   cy2_q;
  logic                  sit_order_q;
  logic [PW-1:0]         p_q;
  logic [CFG_W-1:0]      mul_a;
  logic [MB-1:0]         mul_b;
  logic                  side_ar_q, front_c_q, side_ang_q, front_ang_q;
  logic                  dyn_ang_q, sit_ang_q;

  logic [CW-1:0]         dy256, body256, bw512, p_ext, p_dbl;
  logic                  seen;
  logic [CENTRE_W-1:0]   prev_centre;
  logic [VOTE_WINDOW-1:0] old_bits, new_bits;
  logic signed [DIFF_W-1:0] drop;
  logic                  vel, raw, fall;
  logic [VCNT_W-1:0]     votes;
  logic                  result_valid_q;
  result_t               result_q;

  assign {r_ok, r_track, r_head, r_sx, r_sy, r_hx, r_hy, r_ky, r_ay,
          r_top, r_bw, r_bh} = rec_q;
  assign in_track = rec_i[REC_W-2 -: TRACK_W];

  // track id to slot, folded at elaboration
  for (genvar g = 0; g < TIDS; g++) begin : g_slot
    assign slot_lut[g] = SLOT_W'(g % TRACKS);
  end

  function automatic logic [SUM_W-1:0] absdiff(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // -------------------------------------------------------------------------
  // Clearing pass over the track memory after reset
  // -------------------------------------------------------------------------
  assign clearing_o = (clr_q != CLR_W'(TRACKS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing_o) begin
      clr_q <= clr_q + CLR_W'(1);
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (rec_valid_i && !clearing_o) st_d = ST_LOAD;
      ST_LOAD:   st_d = r_ok ? ST_MUL : ST_DECIDE;
      ST_MUL:    if (step_q == STEP_W'(MUL_OPS)) st_d = ST_DECIDE;
      ST_DECIDE: st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rec_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = slot_q;
    mem_wd    = {1'b1, cy2_q, new_bits};
    case (st_q)
      ST_IDLE:   rec_pop_o = rec_valid_i & ~clearing_o;
      ST_DECIDE: mem_we    = r_ok;
      default: ;
    endcase
    if (clearing_o) begin
      mem_we = 1'b1;
      mem_wa = clr_q[SLOT_W-1:0];
      mem_wd = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (rec_pop_o) begin
      ent_q <= mem_q[slot_lut[in_track]];
    end
  end

  // -------------------------------------------------------------------------
  // Datapath
  // -------------------------------------------------------------------------
  always_comb begin
    case (mul_op_e'(step_q))
      OP_SIDE_RATIO: begin mul_a = cfg_i.side_aspect_ratio;   mul_b = MB'(body2_q); end
      OP_FRONT_COMP: begin mul_a = cfg_i.frontal_compression; mul_b = MB'(r_bh);    end
      OP_SIDE_TAN:   begin mul_a = cfg_i.side_angle_tan;      mul_b = MB'(dx2_q);   end
      OP_FRONT_TAN:  begin mul_a = cfg_i.frontal_angle_tan;   mul_b = MB'(dx2_q);   end
      OP_DYN_TAN:    begin mul_a = cfg_i.dynamic_angle_tan;   mul_b = MB'(dx2_q);   end
      OP_SIT_TAN:    begin mul_a = cfg_i.sitting_angle_tan;   mul_b = MB'(dx2_q);   end
      default:       begin mul_a = '0;                        mul_b = '0;           end
    endcase
  end

  assign dy256   = CW'({dy2_q, 8'b0});
  assign body256 = CW'({body2_q, 8'b0});
  assign bw512   = CW'({r_bw, 9'b0});
  assign p_ext   = CW'(p_q);
  assign p_dbl   = {p_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      rec_q  <= rec_i;
      slot_q <= slot_lut[in_track];
    end
    if (st_q == ST_LOAD) begin
      body2_q     <= absdiff(r_ay, {r_head, 1'b0});
      dx2_q       <= absdiff(r_sx, r_hx);
      dy2_q       <= absdiff(r_sy, r_hy);
      cy2_q       <= CENTRE_W'({r_top, 1'b0}) + CENTRE_W'(r_bh);
      sit_order_q <= (r_ky > r_hy) && (r_ay > r_ky);
      step_q      <= '0;
    end
    if (st_q == ST_MUL) begin
      p_q    <= PW'(mul_a) * PW'(mul_b);
      step_q <= step_q + STEP_W'(1);
      // judge the product formed in the previous step
      if (step_q != '0) begin
        case (mul_op_e'(step_q - STEP_W'(1)))
          OP_SIDE_RATIO: side_ar_q   <= bw512 > p_ext;
          OP_FRONT_COMP: front_c_q   <= (body256 < p_dbl) ||
                                        ((body256 == p_dbl) &&
                                         (cfg_i.frontal_compression != '0));
          OP_SIDE_TAN:   side_ang_q  <= dy256 < p_ext;
          OP_FRONT_TAN:  front_ang_q <= dy256 < p_ext;
          OP_DYN_TAN:    dyn_ang_q   <= dy256 < p_ext;
          OP_SIT_TAN:    sit_ang_q   <= dy256 >= p_ext;
          default: ;
        endcase
      end
    end
  end

  // Decision, vote shift and count
  assign seen        = ent_q[ENT_W-1];
  assign prev_centre = ent_q[VOTE_WINDOW +: CENTRE_W];
  assign old_bits    = ent_q[VOTE_WINDOW-1:0];
  assign drop        = $signed(DIFF_W'(cy2_q)) - $signed(DIFF_W'(prev_centre));
  assign vel         = seen && (drop > $signed(DIFF_W'(cfg_i.drop_speed_limit)));
  assign raw         = ((side_ar_q && side_ang_q) || (front_c_q && front_ang_q) ||
                        (vel && dyn_ang_q)) && !(sit_order_q && sit_ang_q);
  assign new_bits    = VOTE_WINDOW'({old_bits, raw});

  always_comb begin
    votes = '0;
    for (int k = 0; k < VOTE_WINDOW; k++) begin
      votes = votes + VCNT_W'(new_bits[k]);
    end
  end

  assign fall = r_ok && (CMP_W'(votes) >= CMP_W'(cfg_i.vote_threshold));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= (st_q == ST_DECIDE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DECIDE) begin
      result_q.result_track   <= r_track;
      result_q.fall_confirmed <= fall;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  a_strobe_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |-> $past(st_q == ST_DECIDE))
    else $error("result strobe without a decision");

  a_short_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DECIDE && !r_ok) |=> !result_o.fall_confirmed)
    else $error("short frame confirmed a fall");

  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> st_q == ST_IDLE && !rec_pop_o)
    else $error("frame handled during track memory clear");

endmodule

`default_nettype wire

// File: sv/pose_fall_detector.sv
// ----------------------------------------------------------------------------
// pose_fall_detector
// Per-frame fall decision from pose keypoints of tracked persons.
// ----------------------------------------------------------------------------
// Keypoint words are taken one per cycle while busy is low; busy rises only
// while the two-entry frame queue is full or the track memory is being cleared.
// For each frame the decision engine pops the record, loads it, runs 6 multiplies
// on one shared multiplier plus a compare step (both skipped for a short frame)
// and decides; the result strobe is registered from the decide state.
// After reset busy stays high while the track memory clears.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module pose_fall_detector import pfd_pkg::*; #(
  parameter int unsigned TRACKS      = TRACKS_DEF,
  parameter int unsigned VOTE_WINDOW = VOTE_WINDOW_DEF,
  parameter int unsigned KEYPOINTS   = KEYPOINTS_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  item_t                  item_i,
  output logic                   result_valid_o,
  output result_t                result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned REC_W = 1 + TRACK_W + COORD_BITS
                                  + 6 * (COORD_BITS + 1) + 3 * BOX_W;

  cfg_t             cfg;
  logic             accept;
  logic             push, pop, q_empty, q_full, clearing;
  logic [REC_W-1:0] rec_in, rec_out;

  assign busy   = clearing | q_full;
  assign accept = start & ~busy;
  assign pready = 1'b1;

  pfd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  pfd_front #(
    .KEYPOINTS  (KEYPOINTS),
    .COORD_BITS (COORD_BITS),
    .REC_W      (REC_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .push_o   (push),
    .rec_o    (rec_in)
  );

  pfd_fifo #(
    .WIDTH (REC_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (rec_in),
    .pop_i   (pop),
    .data_o  (rec_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  pfd_back #(
    .TRACKS      (TRACKS),
    .VOTE_WINDOW (VOTE_WINDOW),
    .COORD_BITS  (COORD_BITS),
    .REC_W       (REC_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .rec_i          (rec_out),
    .rec_valid_i    (~q_empty),
    .rec_pop_o      (pop),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire
